[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token codes and character helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } src_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        last_of_run;
  } tok_t;

  // up to three tokens leave the scanner per request
  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } push_t;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_NUMDOT,
    MODE_FRACTION,
    MODE_STRING,
    MODE_OPERATOR,
    MODE_SLASH,
    MODE_COMMENT
  } mode_e;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [5:0] K_LBRACE   = 6'd0;
  localparam logic [5:0] K_RBRACE   = 6'd1;
  localparam logic [5:0] K_LPAREN   = 6'd2;
  localparam logic [5:0] K_RPAREN   = 6'd3;
  localparam logic [5:0] K_LBRACKET = 6'd4;
  localparam logic [5:0] K_RBRACKET = 6'd5;
  localparam logic [5:0] K_COMMA    = 6'd6;
  localparam logic [5:0] K_DOT      = 6'd7;
  localparam logic [5:0] K_MINUS    = 6'd8;
  localparam logic [5:0] K_PLUS     = 6'd9;
  localparam logic [5:0] K_SEMI     = 6'd10;
  localparam logic [5:0] K_STAR     = 6'd11;
  localparam logic [5:0] K_SLASH    = 6'd12;
  localparam logic [5:0] K_BANG     = 6'd13;
  localparam logic [5:0] K_EQUAL    = 6'd15;
  localparam logic [5:0] K_GREATER  = 6'd17;
  localparam logic [5:0] K_LESS     = 6'd19;
  localparam logic [5:0] K_IDENT    = 6'd21;
  localparam logic [5:0] K_STRING   = 6'd22;
  localparam logic [5:0] K_NUMBER   = 6'd23;
  localparam logic [5:0] K_END      = 6'd24;
  localparam logic [5:0] K_KEYWORD0 = 6'd25;
  localparam logic [5:0] K_ERROR    = 6'd41;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [63:0] HASH_MUL = 64'd131;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [47:0] KW_TEXT [16] = '{
    48'("and"),   48'("class"), 48'("else"),   48'("false"),
    48'("fun"),   48'("for"),   48'("if"),     48'("nil"),
    48'("or"),    48'("print"), 48'("return"), 48'("super"),
    48'("this"),  48'("true"),  48'("var"),    48'("while")
  };

  localparam int KW_LEN [16] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5};

  function automatic logic [63:0] kw_hash(input int k);
    logic [63:0] h;
    h = '0;
    for (int i = 5; i >= 0; i--) begin
      if (i < KW_LEN[k]) begin
        h = h * HASH_MUL + 64'(KW_TEXT[k][8*i +: 8]);
      end
    end
    return h;
  endfunction

  localparam logic [63:0] KW_HASH [16] = '{
    kw_hash(0),  kw_hash(1),  kw_hash(2),  kw_hash(3),
    kw_hash(4),  kw_hash(5),  kw_hash(6),  kw_hash(7),
    kw_hash(8),  kw_hash(9),  kw_hash(10), kw_hash(11),
    kw_hash(12), kw_hash(13), kw_hash(14), kw_hash(15)
  };

  // lowest matching keyword wins
  function automatic logic [5:0] kw_kind(input logic [63:0] h);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 15; k >= 0; k--) begin
      if (h == KW_HASH[k]) begin
        kind = K_KEYWORD0 + 6'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_BANG) || (c == CH_EQUAL) || (c == CH_LESS) || (c == CH_GREAT);
  endfunction

  function automatic logic single_hit(input logic [7:0] c);
    logic hit;
    case (c)
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h2E,
      8'h2D, 8'h2B, 8'h3B, 8'h2A, CH_NUL: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] kind;
    case (c)
      8'h7B:   kind = K_LBRACE;
      8'h7D:   kind = K_RBRACE;
      8'h28:   kind = K_LPAREN;
      8'h29:   kind = K_RPAREN;
      8'h5B:   kind = K_LBRACKET;
      8'h5D:   kind = K_RBRACKET;
      8'h2C:   kind = K_COMMA;
      8'h2E:   kind = K_DOT;
      8'h2D:   kind = K_MINUS;
      8'h2B:   kind = K_PLUS;
      8'h3B:   kind = K_SEMI;
      8'h2A:   kind = K_STAR;
      default: kind = K_END;
    endcase
    return kind;
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] op);
    logic [5:0] kind;
    case (op)
      CH_BANG:  kind = K_BANG;
      CH_EQUAL: kind = K_EQUAL;
      CH_GREAT: kind = K_GREATER;
      default:  kind = K_LESS;
    endcase
    return kind;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] s, input logic [1:0] n);
    logic [16:0] t;
    t = {1'b0, s} + 17'(n);
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                  input logic [15:0] len, input logic [15:0] line);
    tok_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.token_line   = line;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

[hdl/stt_scan.sv]
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and the per-byte step; produces up to three tokens per request.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan import stt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire src_t  src_i,
  output push_t      push_o
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] begin_q, begin_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [15:0]              line_q, line_d;
  logic [63:0]              hash_q, hash_d;
  logic [7:0]               op_q, op_d;
  logic [15:0]              span_q, span_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
      line_q  <= 16'd1;
      hash_q  <= '0;
      op_q    <= '0;
      span_q  <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      hash_q  <= hash_d;
      op_q    <= op_d;
      span_q  <= span_d;
    end
  end

  always_comb begin
    logic [7:0]               c;
    logic                     last;
    logic                     fresh;
    mode_e                    mode_s;
    logic [15:0]              line_a;
    logic [15:0]              line_b;
    logic [15:0]              begin16;
    logic [15:0]              pos16;
    logic [POSITION_BITS-1:0] pos_prev;
    tok_t                     cand [5];
    logic [4:0]               cand_v;
    logic [2:0]               last_idx;
    logic [2:0]               n;

    c        = src_i.source_byte;
    last     = src_i.end_of_source;
    fresh    = 1'b0;
    mode_s   = mode_q;
    begin_d  = begin_q;
    hash_d   = hash_q;
    op_d     = op_q;
    span_d   = span_q;
    line_a   = line_q;
    begin16  = 16'(begin_q);
    pos16    = 16'(pos_q);
    pos_prev = pos_q - POS_ONE;
    cand_v   = '0;
    for (int i = 0; i < 5; i++) begin
      cand[i] = '0;
    end

    case (mode_q)
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c) || (c == CH_UNDER)) begin
          hash_d = (hash_q << 7) + (hash_q << 1) + hash_q + 64'(c);
          span_d = sat_add(span_q, 2'd1);
        end else begin
          cand[0]   = mk_tok(kw_kind(hash_q), begin16, span_q, line_q);
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          span_d = sat_add(span_q, 2'd1);
        end else if (c == CH_DOT) begin
          mode_s = MODE_NUMDOT;
        end else begin
          cand[0]   = mk_tok(K_NUMBER, begin16, span_q, line_q);
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_NUMDOT: begin
        if (is_digit(c)) begin
          span_d = sat_add(span_q, 2'd2);
          mode_s = MODE_FRACTION;
        end else begin
          cand[0]   = mk_tok(K_NUMBER, begin16, span_q, line_q);
          cand[1]   = mk_tok(K_DOT, 16'(pos_prev), 16'd1, line_q);
          cand_v[1:0] = 2'b11;
          fresh     = 1'b1;
        end
      end
      MODE_FRACTION: begin
        if (is_digit(c)) begin
          span_d = sat_add(span_q, 2'd1);
        end else begin
          cand[0]   = mk_tok(K_NUMBER, begin16, span_q, line_q);
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_STRING: begin
        span_d = sat_add(span_q, 2'd1);
        if ((c == CH_NL) && (line_q != 16'hFFFF)) begin
          line_a = line_q + 16'd1;
        end
        if (c == CH_QUOTE) begin
          cand[0]   = mk_tok(K_STRING, begin16, span_d, line_a);
          cand_v[0] = 1'b1;
          mode_s    = MODE_IDLE;
        end
      end
      MODE_OPERATOR: begin
        if (c == CH_EQUAL) begin
          cand[0] = mk_tok(op_single(op_q) + 6'd1, begin16, 16'd2, line_q);
          mode_s  = MODE_IDLE;
        end else begin
          cand[0] = mk_tok(op_single(op_q), begin16, 16'd1, line_q);
          fresh   = 1'b1;
        end
        cand_v[0] = 1'b1;
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_s = MODE_COMMENT;
        end else begin
          cand[0]   = mk_tok(K_SLASH, begin16, 16'd1, line_q);
          cand_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          if (line_q != 16'hFFFF) begin
            line_a = line_q + 16'd1;
          end
          mode_s = MODE_IDLE;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    line_b = line_a;
    if (fresh) begin
      mode_s  = MODE_IDLE;
      begin_d = pos_q;
      span_d  = 16'd1;
      if (is_letter(c)) begin
        hash_d = 64'(c);
        mode_s = MODE_IDENT;
      end else if (is_digit(c)) begin
        mode_s = MODE_NUMBER;
      end else if (c == CH_QUOTE) begin
        mode_s = MODE_STRING;
      end else if (is_op(c)) begin
        op_d   = c;
        mode_s = MODE_OPERATOR;
      end else if (c == CH_SLASH) begin
        mode_s = MODE_SLASH;
      end else if (c == CH_NL) begin
        if (line_a != 16'hFFFF) begin
          line_b = line_a + 16'd1;
        end
      end else if (single_hit(c)) begin
        cand[2]   = mk_tok(single_kind(c), pos16, 16'd1, line_a);
        cand_v[2] = 1'b1;
      end
    end

    // flush at end of source
    if (last) begin
      case (mode_s)
        MODE_IDENT: begin
          cand[3]   = mk_tok(kw_kind(hash_d), 16'(begin_d), span_d, line_b);
          cand_v[3] = 1'b1;
        end
        MODE_NUMBER, MODE_FRACTION: begin
          cand[3]   = mk_tok(K_NUMBER, 16'(begin_d), span_d, line_b);
          cand_v[3] = 1'b1;
        end
        MODE_NUMDOT: begin
          cand[3]     = mk_tok(K_NUMBER, 16'(begin_d), span_d, line_b);
          cand[4]     = mk_tok(K_DOT, pos16, 16'd1, line_b);
          cand_v[4:3] = 2'b11;
        end
        MODE_STRING: begin
          cand[3]   = mk_tok(K_ERROR, 16'(begin_d), span_d, line_b);
          cand_v[3] = 1'b1;
        end
        MODE_OPERATOR: begin
          cand[3]   = mk_tok(op_single(op_d), 16'(begin_d), 16'd1, line_b);
          cand_v[3] = 1'b1;
        end
        MODE_SLASH: begin
          cand[3]   = mk_tok(K_SLASH, 16'(begin_d), 16'd1, line_b);
          cand_v[3] = 1'b1;
        end
        default: begin
        end
      endcase
      mode_d = MODE_IDLE;
      pos_d  = '0;
      line_d = 16'd1;
    end else begin
      mode_d = mode_s;
      pos_d  = pos_q + POS_ONE;
      line_d = line_b;
    end

    // mark the final token of this request
    last_idx = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand_v[i]) begin
        last_idx = 3'(i);
      end
    end
    if (cand_v != '0) begin
      cand[last_idx].last_of_run = 1'b1;
    end

    // pack valid tokens into the push slots
    n           = '0;
    push_o.tok  = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand_v[i]) begin
        if (n < 3'd3) begin
          push_o.tok[n[1:0]] = cand[i];
        end
        n = n + 3'd1;
      end
    end
    push_o.cnt = fire_i ? n[1:0] : 2'd0;
  end

endmodule

`default_nettype wire

[hdl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per request in, tokens out through a queue.
// ----------------------------------------------------------------------------
// queueing: tokens of a byte are written into the queue registers at the edge
//   that takes the byte, and the output reads the queue head combinationally
// throughput: one byte per cycle while each byte yields at most one token and
//   out_stall_i is low; the four-entry token queue drains one token per
//   unstalled cycle and stalls input while fewer than three entries are free
// reset: asynchronous, scanner idle at offset 0 and line 1, token queue empty
`default_nettype none

module source_text_tokenizer import stt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire src_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output tok_t      out_data_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = PtrW + 1;

  logic            in_fire;
  logic            pop;
  push_t           push;
  tok_t            fifo_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_stall_o  = cnt_q > CntW'(FIFO_DEPTH - 3);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  stt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(in_fire),
    .src_i (in_data_i),
    .push_o(push)
  );

  assign wr_d  = wr_q + PtrW'(push.cnt);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push.cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.cnt) begin
        fifo_q[wr_q + PtrW'(k)] <= push.tok[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FIFO_DEPTH))
    else $error("token queue overflow");

  a_push_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> in_fire)
    else $error("tokens pushed without an accepted byte");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push.cnt == 2'd0)) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("token queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

[sim/stt_token_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stt_token_checker
// Watches both channels of the tokenizer. Every accepted request is run
// through a scanner model kept here, and the tokens it yields are compared in
// order, field by field, with the tokens the block hands out.
// ----------------------------------------------------------------------------
module stt_token_checker import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  wire src_t in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  wire tok_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        token_count_o
);

  localparam logic [5:0]  K_BANG_EQUAL    = 6'd14;
  localparam logic [5:0]  K_EQUAL_EQUAL   = 6'd16;
  localparam logic [5:0]  K_GREATER_EQUAL = 6'd18;
  localparam logic [5:0]  K_LESS_EQUAL    = 6'd20;
  localparam logic [63:0] HASH_FACTOR     = 64'd131;
  localparam int          REPORT_LIMIT    = 10;

  string keyword_words [16] = '{
    "and", "class", "else", "false", "fun", "for", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };
  logic [63:0] keyword_hashes [16];

  mode_e       scan_mode;
  logic [15:0] tok_origin;
  logic [15:0] byte_pos;
  logic [15:0] line_no;
  logic [15:0] tok_span;
  logic [63:0] word_hash;
  logic [7:0]  held_op;
  tok_t        step_toks [$];
  tok_t        awaited_toks [$];
  int          mismatches;
  int          tokens_seen;

  initial begin
    for (int k = 0; k < 16; k++) begin
      keyword_hashes[k] = '0;
      for (int i = 0; i < keyword_words[k].len(); i++) begin
        keyword_hashes[k] = keyword_hashes[k] * HASH_FACTOR + 64'(keyword_words[k][i]);
      end
    end
  end

  function automatic logic alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] grow(input logic [15:0] s, input int n);
    logic [16:0] t;
    t = {1'b0, s} + 17'(n);
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic [5:0] lone_op_kind(input logic [7:0] op);
    case (op)
      CH_BANG:  return K_BANG;
      CH_EQUAL: return K_EQUAL;
      CH_GREAT: return K_GREATER;
      default:  return K_LESS;
    endcase
  endfunction

  function automatic logic [5:0] pair_op_kind(input logic [7:0] op);
    case (op)
      CH_BANG:  return K_BANG_EQUAL;
      CH_EQUAL: return K_EQUAL_EQUAL;
      CH_GREAT: return K_GREATER_EQUAL;
      default:  return K_LESS_EQUAL;
    endcase
  endfunction

  function automatic int punct_kind(input logic [7:0] c);
    case (c)
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "[":     return K_LBRACKET;
      "]":     return K_RBRACKET;
      ",":     return K_COMMA;
      CH_DOT:  return K_DOT;
      "-":     return K_MINUS;
      "+":     return K_PLUS;
      ";":     return K_SEMI;
      "*":     return K_STAR;
      CH_NUL:  return K_END;
      default: return -1;
    endcase
  endfunction

  task automatic bump_line();
    if (line_no != 16'hFFFF) begin
      line_no = line_no + 16'd1;
    end
  endtask

  task automatic queue_token(input logic [5:0] kind, input logic [15:0] start,
                             input logic [15:0] len);
    tok_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.token_line   = line_no;
    t.last_of_run  = 1'b0;
    step_toks = {step_toks, t};
  endtask

  // lowest matching keyword wins
  task automatic queue_word();
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 15; k >= 0; k--) begin
      if (keyword_hashes[k] == word_hash) begin
        kind = K_KEYWORD0 + 6'(k);
      end
    end
    queue_token(kind, tok_origin, tok_span);
  endtask

  task automatic open_token(input logic [7:0] c, input logic [15:0] pos);
    int k;
    scan_mode  = MODE_IDLE;
    tok_origin = pos;
    tok_span   = 16'd1;
    if (alpha(c)) begin
      word_hash = 64'(c);
      scan_mode = MODE_IDENT;
    end else if (numeral(c)) begin
      scan_mode = MODE_NUMBER;
    end else if (c == CH_QUOTE) begin
      scan_mode = MODE_STRING;
    end else if (c == CH_BANG || c == CH_EQUAL || c == CH_LESS || c == CH_GREAT) begin
      held_op   = c;
      scan_mode = MODE_OPERATOR;
    end else if (c == CH_SLASH) begin
      scan_mode = MODE_SLASH;
    end else if (c == CH_NL) begin
      bump_line();
    end else begin
      k = punct_kind(c);
      if (k >= 0) begin
        queue_token(6'(k), pos, 16'd1);
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic eos);
    logic        restart;
    logic [15:0] pos;
    tok_t        t;
    pos     = byte_pos;
    restart = 1'b0;
    step_toks.delete();
    case (scan_mode)
      MODE_IDENT: begin
        if (alpha(c) || numeral(c) || c == CH_UNDER) begin
          word_hash = word_hash * HASH_FACTOR + 64'(c);
          tok_span  = grow(tok_span, 1);
        end else begin
          queue_word();
          restart = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (numeral(c)) begin
          tok_span = grow(tok_span, 1);
        end else if (c == CH_DOT) begin
          scan_mode = MODE_NUMDOT;
        end else begin
          queue_token(K_NUMBER, tok_origin, tok_span);
          restart = 1'b1;
        end
      end
      MODE_NUMDOT: begin
        if (numeral(c)) begin
          tok_span  = grow(tok_span, 2);
          scan_mode = MODE_FRACTION;
        end else begin
          queue_token(K_NUMBER, tok_origin, tok_span);
          queue_token(K_DOT, pos - 16'd1, 16'd1);
          restart = 1'b1;
        end
      end
      MODE_FRACTION: begin
        if (numeral(c)) begin
          tok_span = grow(tok_span, 1);
        end else begin
          queue_token(K_NUMBER, tok_origin, tok_span);
          restart = 1'b1;
        end
      end
      MODE_STRING: begin
        tok_span = grow(tok_span, 1);
        if (c == CH_NL) begin
          bump_line();
        end
        if (c == CH_QUOTE) begin
          queue_token(K_STRING, tok_origin, tok_span);
          scan_mode = MODE_IDLE;
        end
      end
      MODE_OPERATOR: begin
        if (c == CH_EQUAL) begin
          queue_token(pair_op_kind(held_op), tok_origin, 16'd2);
          scan_mode = MODE_IDLE;
        end else begin
          queue_token(lone_op_kind(held_op), tok_origin, 16'd1);
          restart = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          scan_mode = MODE_COMMENT;
        end else begin
          queue_token(K_SLASH, tok_origin, 16'd1);
          restart = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          bump_line();
          scan_mode = MODE_IDLE;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      open_token(c, pos);
    end

    // flush whatever is pending at end of source
    if (eos) begin
      case (scan_mode)
        MODE_IDENT:                 queue_word();
        MODE_NUMBER, MODE_FRACTION: queue_token(K_NUMBER, tok_origin, tok_span);
        MODE_NUMDOT: begin
          queue_token(K_NUMBER, tok_origin, tok_span);
          queue_token(K_DOT, pos, 16'd1);
        end
        MODE_STRING:   queue_token(K_ERROR, tok_origin, tok_span);
        MODE_OPERATOR: queue_token(lone_op_kind(held_op), tok_origin, 16'd1);
        MODE_SLASH:    queue_token(K_SLASH, tok_origin, 16'd1);
        default: ;
      endcase
      scan_mode = MODE_IDLE;
      byte_pos  = '0;
      line_no   = 16'd1;
    end else begin
      byte_pos = pos + 16'd1;
    end

    if (step_toks.size() > 0) begin
      t = step_toks[step_toks.size() - 1];
      t.last_of_run = 1'b1;
      step_toks[step_toks.size() - 1] = t;
    end
    foreach (step_toks[i]) begin
      awaited_toks = {awaited_toks, step_toks[i]};
    end
  endtask

  task automatic report(input string what, input tok_t want, input tok_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%s at %0t: expected kind %0d start %0d len %0d line %0d last %0b",
               what, $time, want.token_kind, want.token_start, want.token_length,
               want.token_line, want.last_of_run);
      $display("  got kind %0d start %0d len %0d line %0d last %0b",
               got.token_kind, got.token_start, got.token_length, got.token_line,
               got.last_of_run);
    end
    mismatches++;
  endtask

  task automatic check_token(input tok_t got);
    tok_t want;
    logic bad;
    tokens_seen++;
    if (awaited_toks.size() == 0) begin
      report("token with none expected", '0, got);
    end else begin
      want = awaited_toks.pop_front();
      bad  = (got.token_kind !== want.token_kind)
          || (got.token_start !== want.token_start)
          || (got.token_length !== want.token_length)
          || (got.token_line !== want.token_line)
          || (got.last_of_run !== want.last_of_run);
      if (bad) begin
        report("token mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode   = MODE_IDLE;
      tok_origin  = '0;
      byte_pos    = '0;
      line_no     = 16'd1;
      tok_span    = '0;
      word_hash   = '0;
      held_op     = '0;
      mismatches  = 0;
      tokens_seen = 0;
      awaited_toks.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      token_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_token(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        scan_byte(in_data_i.source_byte, in_data_i.end_of_source);
      end
      fail_count_o  <= mismatches;
      pending_o     <= awaited_toks.size();
      token_count_o <= tokens_seen;
    end
  end

endmodule

[sim/tb_source_text_tokenizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Feeds the tokenizer a short hand-written source, then randomly built
// sources of tokens, comments and stray bytes. Both sides idle at random and
// the output is held off once for a long stretch. A checker beside the block
// predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         RANDOM_BYTES  = 260;
  localparam int         HOLD_MARK     = 60;
  localparam int         HOLD_CYCLES   = 120;
  localparam int         DRAIN_CYCLES  = 8;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  src_t in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tok_t out_data_o;

  int fail_count;
  int pending;
  int token_count;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int sources      = 0;
  int random_bytes = 0;
  bit sender_calm  = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int stall_run    = 0;
  int recv_calm    = 0;
  int recv_roll;

  string keyword_words [16] = '{
    "and", "class", "else", "false", "fun", "for", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };
  string punct_chars = "{}()[],.-+;*";
  string op_chars    = "!=<>";

  source_text_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  stt_token_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .token_count_o (token_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("source_text_tokenizer verification failed");
      $finish;
    end
  end

  // output side: random stalls, calm stretches, one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && random_bytes >= HOLD_MARK) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm = recv_calm - 1;
      out_stall_i <= 1'b0;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 2) begin
        recv_calm = $urandom_range(50, 150);
        out_stall_i <= 1'b0;
      end else if (recv_roll < 70) begin
        out_stall_i <= 1'b0;
      end else if (recv_roll < 95) begin
        stall_run = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_run = $urandom_range(7, 24);
        out_stall_i <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUOTE) ? CH_NL : c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eos);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{source_byte: b, end_of_source: eos};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (eos) sources++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input bit eos_at_end);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], eos_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_fragment();
    logic [7:0] frag [$];
    logic [7:0] ch;
    string      word;
    bit         noise;
    bit         eos;
    noise = 1'b0;
    case ($urandom_range(0, 11))
      0: begin
        word = keyword_words[$urandom_range(0, 15)];
        for (int i = 0; i < word.len(); i++) frag = {frag, 8'(word[i])};
      end
      1: begin
        frag = {frag, rand_letter()};
        repeat ($urandom_range(0, 6)) begin
          ch   = ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
          frag = {frag, ch};
        end
      end
      2: begin
        repeat ($urandom_range(1, 4)) frag = {frag, rand_digit()};
        case ($urandom_range(0, 2))
          1: begin
            frag = {frag, CH_DOT};
            repeat ($urandom_range(1, 3)) frag = {frag, rand_digit()};
          end
          2: frag = {frag, CH_DOT};
          default: ;
        endcase
      end
      3: begin
        frag = {frag, CH_QUOTE};
        repeat ($urandom_range(0, 6)) frag = {frag, rand_text_char()};
        if ($urandom_range(0, 5) != 0) frag = {frag, CH_QUOTE};
      end
      4: begin
        frag = {frag, 8'(op_chars[$urandom_range(0, 3)])};
        if ($urandom_range(0, 1)) frag = {frag, CH_EQUAL};
      end
      5: frag = {frag, 8'(punct_chars[$urandom_range(0, 11)])};
      6: begin
        frag = {frag, CH_SLASH};
        if ($urandom_range(0, 1)) begin
          frag = {frag, CH_SLASH};
          repeat ($urandom_range(0, 8)) frag = {frag, rand_text_char()};
          frag = {frag, CH_NL};
        end
      end
      7: begin
        case ($urandom_range(0, 2))
          0:       frag = {frag, CH_SPACE};
          1:       frag = {frag, CH_NL};
          default: frag = {frag, CH_TAB};
        endcase
      end
      8, 9: begin
        frag  = {frag, 8'($urandom_range(0, 255))};
        noise = 1'b1;
      end
      10: frag = {frag, CH_NUL};
      default: begin
        if ($urandom_range(0, 1)) begin
          frag = {frag, rand_letter()};
          frag = {frag, CH_UNDER};
          frag = {frag, rand_digit()};
        end else begin
          frag = {frag, CH_UNDER};
          frag = {frag, rand_letter()};
        end
      end
    endcase
    if ($urandom_range(0, 2) == 0) frag = {frag, CH_SPACE};
    sender_calm = ($urandom_range(0, 4) == 0);
    foreach (frag[i]) begin
      eos = ((i == frag.size() - 1) && ($urandom_range(0, 14) == 0))
         || ($urandom_range(0, 199) == 0);
      push_byte(frag[i], eos);
    end
    if (!noise) random_bytes += frag.size();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_text("while(n1_>=4.){x==y}", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_NUL, 1'b0);
    send_text("\"q", 1'b1);

    while (random_bytes < RANDOM_BYTES) send_fragment();
    send_text(";", 1'b1);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d source bytes in %0d sources, %0d tokens compared",
             bytes_sent, sources, token_count);
    $display("random idling on both sides and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("source_text_tokenizer verification clean");
    end else begin
      $display("source_text_tokenizer verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/stt_pkg.sv
hdl/stt_scan.sv
hdl/source_text_tokenizer.sv
sim/stt_token_checker.sv
sim/tb_source_text_tokenizer.sv
